/* design/swsp_pkg.sv */
// ----------------------------------------------------------------------------
// swsp_pkg: shared types, constants and float helpers
// Single-precision helpers for non-negative add, operand normalize, restoring
// divide steps and final rounding, plus the pipeline payload types.
// ----------------------------------------------------------------------------
package swsp_pkg;

	localparam int PALETTE_SIZE = 64;
	localparam int NUM_INFL     = 4;
	localparam int NUM_WOUT     = 3;
	localparam int QBITS        = 25;              // 24 mantissa bits + guard
	localparam int DIV_STEPS    = 5;               // quotient bits per stage
	localparam int DIV_STAGES   = QBITS / DIV_STEPS;

	localparam logic [8:0]  PAL_LIMIT  = 9'(PALETTE_SIZE);
	localparam logic [7:0]  EXP_MAX    = 8'hFF;
	localparam logic [31:0] FP_ONE     = 32'h3F80_0000;
	localparam logic [30:0] FP_INF_MAG = 31'h7F80_0000;
	localparam logic [9:0]  EXP_BIAS   = 10'd127;

	localparam logic REG_BONE_COUNT   = 1'b0;
	localparam logic REG_VERTEX_COUNT = 1'b1;

	typedef struct packed {
		logic                    rejected;
		logic                    fixed;
		logic [3:0][31:0]        w;
		logic [3:0][7:0]         bone;
	} san_t;

	typedef struct packed {
		san_t        base;
		logic [30:0] acc;
	} sum_t;

	typedef struct packed {
		logic                    rejected;
		logic                    fixed;
		logic                    sum_ok;
		logic [2:0][31:0]        w;
		logic [3:0][7:0]         bone;
		logic [23:0]             ms;
		logic [2:0][25:0]        rem;
		logic [2:0][24:0]        q;
		logic [2:0][9:0]         eq;
		logic [2:0]              zero;
	} div_t;

	typedef struct packed {
		logic [9:0]  e;
		logic [23:0] m;
	} nrm_t;

	typedef struct packed {
		logic [2:0][31:0] w;
		logic [3:0][7:0]  bone;
		logic             repaired;
		logic             rejected;
	} res_t;

	// x + y for non-negative magnitudes, round to nearest even
	function automatic logic [30:0] fadd_mag(logic [30:0] x, logic [30:0] y);
		logic [30:0] big, sml;
		logic [8:0]  eb, es, e;
		logic [7:0]  d;
		logic [23:0] mb, ms, m;
		logic [26:0] bs, sh;
		logic        lost, g, st, inc;
		logic [27:0] s;
		logic [31:0] res;
		if (x[30:23] == EXP_MAX || y[30:23] == EXP_MAX) return FP_INF_MAG;
		big  = (x >= y) ? x : y;
		sml  = (x >= y) ? y : x;
		eb   = (big[30:23] == 8'd0) ? 9'd1 : {1'b0, big[30:23]};
		es   = (sml[30:23] == 8'd0) ? 9'd1 : {1'b0, sml[30:23]};
		mb   = {|big[30:23], big[22:0]};
		ms   = {|sml[30:23], sml[22:0]};
		d    = 8'(eb - es);
		bs   = {ms, 3'b000};
		sh   = bs >> d;
		lost = (sh << d) != bs;
		s    = {1'b0, mb, 3'b000} + {1'b0, sh[26:1], sh[0] | lost};
		e    = eb;
		if (s[27]) begin
			s = {1'b0, s[27:2], s[1] | s[0]};
			e = e + 9'd1;
		end
		m   = s[26:3];
		g   = s[2];
		st  = s[1] | s[0];
		inc = g & (st | m[0]);
		res = ({23'b0, e - 9'd1} << 23) + {8'b0, m} + {31'b0, inc};
		if (res[30:23] == EXP_MAX) return FP_INF_MAG;
		return res[30:0];
	endfunction

	// normalized mantissa and unbiased-plus-bias exponent (subnormals shifted up)
	function automatic nrm_t fnorm(logic [30:0] x);
		logic [23:0] m0;
		logic [4:0]  lz;
		logic [9:0]  e0;
		nrm_t        r;
		m0 = {|x[30:23], x[22:0]};
		lz = 5'd0;
		for (int i = 0; i < 24; i++) begin
			if (m0[i]) lz = 5'(23 - i);
		end
		e0  = (x[30:23] == 8'd0) ? 10'd1 : {2'b0, x[30:23]};
		r.m = m0 << lz;
		r.e = e0 - {5'b0, lz};
		return r;
	endfunction

	// DIV_STEPS restoring steps on every lane
	function automatic div_t div_iter(div_t d);
		div_t r;
		logic bq;
		r = d;
		for (int i = 0; i < DIV_STEPS; i++) begin
			for (int k = 0; k < NUM_WOUT; k++) begin
				bq = r.rem[k] >= {2'b0, r.ms};
				if (bq) r.rem[k] = r.rem[k] - {2'b0, r.ms};
				r.q[k]   = {r.q[k][QBITS-2:0], bq};
				r.rem[k] = {r.rem[k][24:0], 1'b0};
			end
		end
		return r;
	endfunction

	// quotient to single bits, with gradual underflow
	function automatic logic [30:0] fround(logic [24:0] q, logic sticky, logic [9:0] eq);
		logic [7:0]  sh;
		logic [24:0] shv;
		logic [23:0] m;
		logic [8:0]  e;
		logic        g, st, inc;
		logic [31:0] res;
		if (!eq[9] && eq != 10'd0) begin
			m  = q[24:1];
			g  = q[0];
			st = sticky;
			e  = eq[8:0];
		end else begin
			sh  = 8'(10'd1 - eq);
			shv = q >> sh;
			m   = shv[24:1];
			g   = shv[0];
			st  = ((shv << sh) != q) | sticky;
			e   = 9'd1;
		end
		inc = g & (st | m[0]);
		res = ({23'b0, e - 9'd1} << 23) + {8'b0, m} + {31'b0, inc};
		return res[30:0];
	endfunction

endpackage

/* design/swsp_in_if.sv */
// ----------------------------------------------------------------------------
// swsp_in_if: vertex input channel
// Valid/ready channel carrying one skinned vertex per beat.
// ----------------------------------------------------------------------------
interface swsp_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] source_index;
	logic [31:0] weight_a;
	logic [31:0] weight_b;
	logic [31:0] weight_c;
	logic [31:0] weight_d;
	logic [7:0]  bone_a;
	logic [7:0]  bone_b;
	logic [7:0]  bone_c;
	logic [7:0]  bone_d;

	modport source(output valid, source_index, weight_a, weight_b, weight_c, weight_d,
		bone_a, bone_b, bone_c, bone_d, input ready);
	modport sink(input valid, source_index, weight_a, weight_b, weight_c, weight_d,
		bone_a, bone_b, bone_c, bone_d, output ready);
endinterface

/* design/swsp_out_if.sv */
// ----------------------------------------------------------------------------
// swsp_out_if: sanitized vertex output channel
// Valid/ready channel carrying one packed result per beat.
// ----------------------------------------------------------------------------
interface swsp_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_weight_a;
	logic [31:0] out_weight_b;
	logic [31:0] out_weight_c;
	logic [7:0]  out_bone_a;
	logic [7:0]  out_bone_b;
	logic [7:0]  out_bone_c;
	logic [7:0]  out_bone_d;
	logic        repaired;
	logic        rejected;

	modport source(output valid, out_weight_a, out_weight_b, out_weight_c, out_bone_a,
		out_bone_b, out_bone_c, out_bone_d, repaired, rejected, input ready);
	modport sink(input valid, out_weight_a, out_weight_b, out_weight_c, out_bone_a,
		out_bone_b, out_bone_c, out_bone_d, repaired, rejected, output ready);
endinterface

/* design/swsp_sanitize.sv */
// ----------------------------------------------------------------------------
// swsp_sanitize: range checks and weight/index repair (stage 1)
// Flags rejection, zeroes bad weights and invalid palette entries.
// ----------------------------------------------------------------------------
module swsp_sanitize import swsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [8:0]  bone_count,
	input  logic [15:0] vertex_count,
	swsp_in_if.sink     vtx_in,
	output logic        out_valid,
	input  logic        out_ready,
	output san_t        out_data
);

	logic             vld_s1;
	san_t             data_s1;
	san_t             nxt;
	logic             en;
	logic [3:0][31:0] raw_w;
	logic [3:0][7:0]  raw_b;
	logic             bad_w, bad_b;

	assign en           = !vld_s1 || out_ready;
	assign vtx_in.ready = en;
	assign out_valid    = vld_s1;
	assign out_data     = data_s1;

	assign raw_w = {vtx_in.weight_d, vtx_in.weight_c, vtx_in.weight_b, vtx_in.weight_a};
	assign raw_b = {vtx_in.bone_d, vtx_in.bone_c, vtx_in.bone_b, vtx_in.bone_a};

	always_comb begin
		nxt.rejected = vtx_in.source_index >= vertex_count;
		nxt.fixed    = 1'b0;
		bad_w        = 1'b0;
		bad_b        = 1'b0;
		for (int k = 0; k < NUM_INFL; k++) begin
			// NaN/inf, or strictly negative (-0 passes untouched)
			bad_w = (raw_w[k][30:23] == EXP_MAX) || (raw_w[k][31] && |raw_w[k][30:0]);
			bad_b = ({1'b0, raw_b[k]} >= bone_count) || ({1'b0, raw_b[k]} >= PAL_LIMIT);
			nxt.w[k]    = (bad_w || bad_b) ? 32'd0 : raw_w[k];
			nxt.bone[k] = bad_b ? 8'd0 : raw_b[k];
			nxt.fixed   = nxt.fixed | bad_w | bad_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vtx_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			data_s1 <= nxt;
		end
	end

endmodule

/* design/swsp_sum.sv */
// ----------------------------------------------------------------------------
// swsp_sum: ordered weight sum (stages 2..4)
// One single-precision add per stage: ((w0 + w1) + w2) + w3.
// ----------------------------------------------------------------------------
module swsp_sum import swsp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  san_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output sum_t out_data
);

	localparam int NSTG = 3;

	logic [NSTG-1:0] vld_s;
	sum_t            data_s [NSTG];
	logic [NSTG-1:0] en;

	always_comb begin
		en[NSTG-1] = !vld_s[NSTG-1] || out_ready;
		for (int k = NSTG - 2; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_s[NSTG-1];
	assign out_data  = data_s[NSTG-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) vld_s[0] <= in_valid;
			for (int k = 1; k < NSTG; k++) begin
				if (en[k]) vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// sign dropped: only -0 can carry it, and 0 + -0 is +0
	always_ff @(posedge clk) begin
		if (en[0]) begin
			data_s[0].base <= in_data;
			data_s[0].acc  <= fadd_mag(in_data.w[0][30:0], in_data.w[1][30:0]);
		end
		for (int k = 1; k < NSTG; k++) begin
			if (en[k]) begin
				data_s[k].base <= data_s[k-1].base;
				data_s[k].acc  <= fadd_mag(data_s[k-1].acc, data_s[k-1].base.w[k+1][30:0]);
			end
		end
	end

endmodule

/* design/swsp_div.sv */
// ----------------------------------------------------------------------------
// swsp_div: pipelined weight divide (stages 5..10)
// Normalizes operands, then a restoring divider, DIV_STEPS bits per stage.
// ----------------------------------------------------------------------------
module swsp_div import swsp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sum_t in_data,
	output logic out_valid,
	input  logic out_ready,
	output div_t out_data
);

	localparam int NSTG = DIV_STAGES + 1;

	logic [NSTG-1:0] vld_s;
	div_t            data_s [NSTG];
	logic [NSTG-1:0] en;
	div_t            pre;
	nrm_t            ns, nw;
	logic            lt;
	logic [24:0]     mw;

	always_comb begin
		en[NSTG-1] = !vld_s[NSTG-1] || out_ready;
		for (int k = NSTG - 2; k >= 0; k--) begin
			en[k] = !vld_s[k] || en[k+1];
		end
	end

	assign in_ready  = en[0];
	assign out_valid = vld_s[NSTG-1];
	assign out_data  = data_s[NSTG-1];

	always_comb begin
		ns           = fnorm(in_data.acc);
		nw           = '0;
		lt           = 1'b0;
		mw           = '0;
		pre.rejected = in_data.base.rejected;
		pre.fixed    = in_data.base.fixed;
		pre.sum_ok   = (in_data.acc != 31'd0) && (in_data.acc[30:23] != EXP_MAX);
		pre.bone     = in_data.base.bone;
		pre.ms       = ns.m;
		for (int k = 0; k < NUM_WOUT; k++) begin
			nw          = fnorm(in_data.base.w[k][30:0]);
			lt          = nw.m < ns.m;
			mw          = lt ? {nw.m, 1'b0} : {1'b0, nw.m};
			pre.w[k]    = in_data.base.w[k];
			pre.rem[k]  = {1'b0, mw};
			pre.q[k]    = '0;
			pre.eq[k]   = nw.e - ns.e + EXP_BIAS - {9'b0, lt};
			pre.zero[k] = in_data.base.w[k][30:0] == 31'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) vld_s[0] <= in_valid;
			for (int k = 1; k < NSTG; k++) begin
				if (en[k]) vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) data_s[0] <= pre;
		for (int k = 1; k < NSTG; k++) begin
			if (en[k]) data_s[k] <= div_iter(data_s[k-1]);
		end
	end

endmodule

/* design/swsp_pack.sv */
// ----------------------------------------------------------------------------
// swsp_pack: rounding, fallback select and output register (stage 11)
// Rounds quotients, picks pass-through, divided or fallback result.
// ----------------------------------------------------------------------------
module swsp_pack import swsp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  div_t      in_data,
	swsp_out_if.source vtx_out
);

	logic vld_s11;
	res_t res_s11;
	res_t nxt;
	logic en;
	logic [2:0][31:0] qw;

	assign en        = !vld_s11 || vtx_out.ready;
	assign in_ready  = en;

	always_comb begin
		for (int k = 0; k < NUM_WOUT; k++) begin
			qw[k] = in_data.zero[k] ? {in_data.w[k][31], 31'd0} :
				{in_data.w[k][31], fround(in_data.q[k], |in_data.rem[k], in_data.eq[k])};
		end
		nxt = '0;
		if (in_data.rejected) begin
			nxt.rejected = 1'b1;
		end else if (!in_data.fixed) begin
			nxt.w    = in_data.w;
			nxt.bone = in_data.bone;
		end else if (!in_data.sum_ok) begin
			// degenerate sum: all weight on palette entry zero
			nxt.w[0]    = FP_ONE;
			nxt.repaired = 1'b1;
		end else begin
			nxt.w        = qw;
			nxt.bone     = in_data.bone;
			nxt.repaired = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s11 <= 1'b0;
		end else if (en) begin
			vld_s11 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) res_s11 <= nxt;
	end

	assign vtx_out.valid        = vld_s11;
	assign vtx_out.out_weight_a = res_s11.w[0];
	assign vtx_out.out_weight_b = res_s11.w[1];
	assign vtx_out.out_weight_c = res_s11.w[2];
	assign vtx_out.out_bone_a   = res_s11.bone[0];
	assign vtx_out.out_bone_b   = res_s11.bone[1];
	assign vtx_out.out_bone_c   = res_s11.bone[2];
	assign vtx_out.out_bone_d   = res_s11.bone[3];
	assign vtx_out.repaired     = res_s11.repaired;
	assign vtx_out.rejected     = res_s11.rejected;

	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s11 && res_s11.rejected |-> !res_s11.repaired && res_s11.w == '0
			&& res_s11.bone == '0)
		else $error("rejected vertex carries payload");

	a_finite_out: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s11 && res_s11.repaired |-> res_s11.w[0][30:23] != EXP_MAX
			&& res_s11.w[1][30:23] != EXP_MAX && res_s11.w[2][30:23] != EXP_MAX)
		else $error("repaired weight not finite");

	a_unit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s11 && res_s11.repaired |-> res_s11.w[0][30:0] <= FP_ONE[30:0]
			&& res_s11.w[1][30:0] <= FP_ONE[30:0] && res_s11.w[2][30:0] <= FP_ONE[30:0])
		else $error("normalized weight above one");

endmodule

/* design/skin_weight_sanitize_pack.sv */
// ----------------------------------------------------------------------------
// skin_weight_sanitize_pack: skinning weight and palette index repair
// Top level: configuration registers and the eleven-stage vertex pipeline.
// ----------------------------------------------------------------------------
// One vertex beat is taken every clock when the output side keeps up; a
// stall at the output backs up only the stages that are full, so empty
// slots still fill. Stage 1 checks the source index against vertex_count,
// zeroes NaN, infinite and negative weights (-0 stays -0) and clears palette
// indices at or above bone_count or the palette size along with their
// weight. Stages 2..4 form the single-precision sum in order w0..w3, one
// rounded add each. Stage 5 normalizes the sum and the first three weights;
// stages 6..10 are a restoring divider, five quotient bits per stage on
// three lanes in parallel. Stage 11 rounds to nearest even (subnormal
// quotients included) and picks the untouched weights, the divided ones, or
// the weight-one-on-entry-zero fallback when the sum is zero or overflows. A
// rejected vertex comes out with every field zero except the rejected flag.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while the pipeline is empty, the block does not enforce it.
// ----------------------------------------------------------------------------
module skin_weight_sanitize_pack import swsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	swsp_in_if.sink     vtx_in,
	swsp_out_if.source  vtx_out
);

	logic [8:0]  bone_count_q;
	logic [15:0] vertex_count_q;

	// stage-to-stage beats
	logic san_vld, san_rdy;
	san_t san_data;
	logic sum_vld, sum_rdy;
	sum_t sum_data;
	logic div_vld, div_rdy;
	div_t div_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bone_count_q   <= 9'd256;
			vertex_count_q <= 16'hFFFF;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_BONE_COUNT:   bone_count_q   <= cfg_data[8:0];
				REG_VERTEX_COUNT: vertex_count_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	swsp_sanitize u_sanitize (
		.clk          (clk),
		.arst_n       (arst_n),
		.bone_count   (bone_count_q),
		.vertex_count (vertex_count_q),
		.vtx_in       (vtx_in),
		.out_valid    (san_vld),
		.out_ready    (san_rdy),
		.out_data     (san_data)
	);

	swsp_sum u_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (san_vld),
		.in_ready  (san_rdy),
		.in_data   (san_data),
		.out_valid (sum_vld),
		.out_ready (sum_rdy),
		.out_data  (sum_data)
	);

	swsp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sum_vld),
		.in_ready  (sum_rdy),
		.in_data   (sum_data),
		.out_valid (div_vld),
		.out_ready (div_rdy),
		.out_data  (div_data)
	);

	swsp_pack u_pack (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (div_vld),
		.in_ready (div_rdy),
		.in_data  (div_data),
		.vtx_out  (vtx_out)
	);

endmodule

/* test/tb_skin_weight_sanitize_pack.sv */
// ----------------------------------------------------------------------------
// tb_skin_weight_sanitize_pack: self-checking bench for the weight sanitizer
// Drives vertex beats with random gaps and output stalls, predicts each result
// with exact integer float arithmetic and checks every output beat in order.
// ----------------------------------------------------------------------------
module tb_skin_weight_sanitize_pack import swsp_pkg::*;;

	typedef struct packed {
		logic [15:0]      source_index;
		logic [3:0][31:0] w;
		logic [3:0][7:0]  bone;
	} vtx_t;

	localparam logic [30:0] MAG_INF = 31'h7F80_0000;

	// Round an exact value m * 2^s (m >= 0) to a single-precision magnitude, RNE.
	function automatic logic [30:0] round_single(logic [319:0] m, int s);
		int          p, e_b, sh;
		logic [319:0] q, r, half;
		logic [63:0] bits;
		if (m == 0) return 31'd0;
		p = 0;
		for (int i = 0; i < 320; i++) begin
			if (m[i]) p = i;
		end
		e_b = p + s + 127;
		if (e_b < 1) e_b = 1;                  // subnormal range
		sh = e_b - 150 - s;
		if (sh <= 0) begin
			q = m << (-sh);
		end else if (sh >= 320) begin
			return 31'd0;
		end else begin
			q    = m >> sh;
			r    = m - (q << sh);
			half = 320'd1 << (sh - 1);
			if (r > half || (r == half && q[0])) q = q + 1;
		end
		bits = (64'(e_b - 1) << 23) + q[63:0];
		if (bits >= 64'h7F80_0000) return MAG_INF;
		return bits[30:0];
	endfunction

	function automatic int exp_of(logic [30:0] a);
		return (a[30:23] == 8'd0) ? 1 : int'(a[30:23]);
	endfunction

	function automatic logic [23:0] mant_of(logic [30:0] a);
		return {|a[30:23], a[22:0]};
	endfunction

	// sum of two non-negative finite-or-inf magnitudes
	function automatic logic [30:0] mag_add(logic [30:0] a, logic [30:0] b);
		int ea, eb, el;
		logic [319:0] m;
		if (a[30:23] == EXP_MAX || b[30:23] == EXP_MAX) return MAG_INF;
		ea = exp_of(a);
		eb = exp_of(b);
		el = (ea < eb) ? ea : eb;
		m  = (320'(mant_of(a)) << (ea - el)) + (320'(mant_of(b)) << (eb - el));
		return round_single(m, el - 150);
	endfunction

	// quotient of magnitudes, divisor positive and finite
	function automatic logic [30:0] mag_div(logic [30:0] a, logic [30:0] b);
		logic [319:0] num, q;
		logic         sticky;
		if (a == 31'd0) return 31'd0;
		num    = 320'(mant_of(a)) << 64;
		q      = num / 320'(mant_of(b));
		sticky = (num % 320'(mant_of(b))) != 0;
		q      = (q << 1) | 320'(sticky);
		return round_single(q, exp_of(a) - exp_of(b) - 65);
	endfunction

	class vertex_scoreboard;
		logic [8:0]  bone_count;
		logic [15:0] vertex_count;
		res_t        expected_q[$];
		int          errors;
		int          beats_checked;
		int          n_rejected;
		int          n_repaired;
		int          n_fallback;

		function void reset_regs();
			bone_count   = 9'd256;
			vertex_count = 16'hFFFF;
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			errors++;
			$display("MISMATCH beat %0d %s: got %h expected %h", beats_checked, what,
				got, want);
		endtask

		// work out the sanitized result of one accepted vertex
		function void note_vertex(vtx_t v);
			res_t        r;
			logic [3:0][31:0] w;
			logic [3:0][7:0]  pal;
			logic        fixed;
			logic [30:0] sum;
			r = '0;
			if (v.source_index >= vertex_count) begin
				r.rejected = 1'b1;
				n_rejected++;
				expected_q.push_back(r);
				return;
			end
			fixed = 1'b0;
			sum   = 31'd0;
			w     = v.w;
			pal   = v.bone;
			for (int k = 0; k < NUM_INFL; k++) begin
				// NaN, infinity or a negative nonzero value; -0 is kept
				if (w[k][30:23] == EXP_MAX || (w[k][31] && w[k][30:0] != 0)) begin
					w[k]  = 32'd0;
					fixed = 1'b1;
				end
				if (9'(pal[k]) >= bone_count || 9'(pal[k]) >= PAL_LIMIT) begin
					pal[k] = 8'd0;
					w[k]   = 32'd0;
					fixed  = 1'b1;
				end
				sum = mag_add(sum, w[k][30:0]);
			end
			if (fixed) begin
				n_repaired++;
				if (sum != 0 && sum[30:23] != EXP_MAX) begin
					for (int k = 0; k < NUM_INFL; k++)
						w[k] = {w[k][31], mag_div(w[k][30:0], sum)};
				end else begin
					n_fallback++;
					w   = '0;
					w[0] = FP_ONE;
					pal = '0;
				end
			end
			for (int k = 0; k < NUM_WOUT; k++) r.w[k] = w[k];
			r.bone     = pal;
			r.repaired = fixed;
			expected_q.push_back(r);
		endfunction

		task check_result(res_t got);
			res_t want;
			if (expected_q.size() == 0) begin
				report("result beat with nothing expected", 32'd1, 32'd0);
				return;
			end
			want = expected_q.pop_front();
			for (int k = 0; k < NUM_WOUT; k++)
				if (got.w[k] !== want.w[k]) report($sformatf("weight %0d", k), got.w[k],
					want.w[k]);
			for (int k = 0; k < NUM_INFL; k++)
				if (got.bone[k] !== want.bone[k]) report($sformatf("bone %0d", k),
					32'(got.bone[k]), 32'(want.bone[k]));
			if (got.repaired !== want.repaired)
				report("repaired", 32'(got.repaired), 32'(want.repaired));
			if (got.rejected !== want.rejected)
				report("rejected", 32'(got.rejected), 32'(want.rejected));
			beats_checked++;
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_index;
	logic [15:0] cfg_data;

	swsp_in_if  vtx_in();
	swsp_out_if vtx_out();

	skin_weight_sanitize_pack u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.vtx_in    (vtx_in.sink),
		.vtx_out   (vtx_out.source)
	);

	vertex_scoreboard sb;
	int  cycles;
	bit  quiet;        // no gaps or stalls in this phase
	bit  long_hold;    // ask the receiver for one long stall
	int  phases_run;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit: generous over 740 beats with worst gaps, stalls and the hold
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("timeout after %0d cycles, %0d beats pending", cycles,
				sb.expected_q.size());
			$display("tb_skin_weight_sanitize_pack: done, errors");
			$finish;
		end
	end

	// input beat monitor: note every accepted vertex
	always @(posedge clk) begin
		vtx_t v;
		if (arst_n && vtx_in.valid && vtx_in.ready) begin
			v.source_index = vtx_in.source_index;
			v.w    = {vtx_in.weight_d, vtx_in.weight_c, vtx_in.weight_b, vtx_in.weight_a};
			v.bone = {vtx_in.bone_d, vtx_in.bone_c, vtx_in.bone_b, vtx_in.bone_a};
			sb.note_vertex(v);
		end
	end

	// output beat monitor
	always @(posedge clk) begin
		res_t r;
		if (arst_n && vtx_out.valid && vtx_out.ready) begin
			r.w        = {vtx_out.out_weight_c, vtx_out.out_weight_b, vtx_out.out_weight_a};
			r.bone     = {vtx_out.out_bone_d, vtx_out.out_bone_c, vtx_out.out_bone_b,
				vtx_out.out_bone_a};
			r.repaired = vtx_out.repaired;
			r.rejected = vtx_out.rejected;
			sb.check_result(r);
		end
	end

	// receiver: random stall per beat, one long hold when asked
	initial begin
		int n;
		vtx_out.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (long_hold) begin
				vtx_out.ready = 1'b0;
				repeat (200) @(negedge clk);
				long_hold = 1'b0;
			end
			n = quiet ? 0 : $urandom_range(0, 13);
			if (n > 0) begin
				vtx_out.ready = 1'b0;
				repeat (n - 1) @(negedge clk);
				@(negedge clk);
			end
			vtx_out.ready = 1'b1;
			do @(posedge clk); while (!vtx_out.valid);
		end
	end

	task send_vertex(vtx_t v);
		int n;
		n = quiet ? 0 : $urandom_range(0, 13);
		if (n > 0) begin
			vtx_in.valid = 1'b0;
			repeat (n) @(negedge clk);
		end
		vtx_in.valid        = 1'b1;
		vtx_in.source_index = v.source_index;
		vtx_in.weight_a     = v.w[0];
		vtx_in.weight_b     = v.w[1];
		vtx_in.weight_c     = v.w[2];
		vtx_in.weight_d     = v.w[3];
		vtx_in.bone_a       = v.bone[0];
		vtx_in.bone_b       = v.bone[1];
		vtx_in.bone_c       = v.bone[2];
		vtx_in.bone_d       = v.bone[3];
		do @(posedge clk); while (!vtx_in.ready);
		@(negedge clk);
	endtask

	// pipeline drained, then a register write at a quiet point
	task write_reg(logic idx, logic [15:0] value);
		vtx_in.valid = 1'b0;
		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (15) @(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = value;
		if (idx == REG_BONE_COUNT) sb.bone_count = value[8:0];
		else sb.vertex_count = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic [31:0] rand_weight();
		case ($urandom_range(0, 11))
			0:  return 32'h0000_0000;
			1:  return 32'h8000_0000;                          // negative zero
			2:  return {9'd0, 23'($urandom)};                  // subnormal
			3:  return {1'($urandom), 8'hFF, 23'($urandom)};   // inf / NaN
			4:  return {1'b1, 31'($urandom)};                  // negative
			5:  return 32'h7F7F_FFFF;                          // largest finite
			6:  return $urandom;
			default: return {1'b0, 8'($urandom_range(100, 140)), 23'($urandom)};
		endcase
	endfunction

	function automatic vtx_t rand_vertex();
		vtx_t v;
		int   vc, bc;
		vc = int'(sb.vertex_count);
		bc = int'(sb.bone_count);
		if (vc > 0 && $urandom_range(0, 9) != 0) v.source_index = 16'($urandom_range(0, vc - 1));
		else v.source_index = 16'($urandom);
		for (int k = 0; k < NUM_INFL; k++) begin
			// mostly clean weights so the no-repair path is common too
			v.w[k] = ($urandom_range(0, 2) == 0) ? rand_weight()
				: {1'b0, 8'($urandom_range(110, 130)), 23'($urandom)};
			if (bc > 0 && $urandom_range(0, 7) != 0)
				v.bone[k] = 8'($urandom_range(0, ((bc < 64) ? bc : 64) - 1));
			else
				v.bone[k] = 8'($urandom);
		end
		return v;
	endfunction

	function automatic vtx_t mk(logic [15:0] si, logic [31:0] a, logic [31:0] b,
		logic [31:0] c, logic [31:0] d, logic [31:0] bones);
		vtx_t v;
		v.source_index = si;
		v.w    = {d, c, b, a};
		v.bone = bones;
		return v;
	endfunction

	// register settings per random phase: {bone_count, vertex_count}
	logic [8:0]  bc_set[6] = '{9'd256, 9'd64, 9'd0, 9'd10, 9'd63, 9'd1};
	logic [15:0] vc_set[6] = '{16'hFFFF, 16'd1000, 16'd0, 16'hFFFF, 16'd30000, 16'd1};

	initial begin
		sb = new();
		sb.reset_regs();
		cycles = 0;
		quiet = 1'b0;
		long_hold = 1'b0;
		phases_run = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_BONE_COUNT;
		cfg_data = '0;
		vtx_in.valid = 1'b0;
		vtx_in.source_index = '0;
		vtx_in.weight_a = '0;
		vtx_in.weight_b = '0;
		vtx_in.weight_c = '0;
		vtx_in.weight_d = '0;
		vtx_in.bone_a = '0;
		vtx_in.bone_b = '0;
		vtx_in.bone_c = '0;
		vtx_in.bone_d = '0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed beats at reset settings (256 bones, 65535 vertices)
		send_vertex(mk(16'd0, 32'h3E80_0000, 32'h3E80_0000, 32'h3E80_0000,
			32'h3E80_0000, 32'h0403_0201));                  // clean, no repair
		send_vertex(mk(16'hFFFF, 32'h3F80_0000, 0, 0, 0, 0));   // source index rejected
		send_vertex(mk(16'hFFFE, 32'h8000_0000, 32'h3F00_0000, 32'h3F80_0000,
			32'h0, 32'h4001_0203));                           // -0 kept, bone 64 cleared
		send_vertex(mk(16'd5, 32'h7FC0_0000, 32'h7F80_0000, 32'hBF80_0000,
			32'h4000_0000, 32'h0000_0000));                   // NaN, inf, negative
		send_vertex(mk(16'd6, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFF));                   // all invalid: fallback
		send_vertex(mk(16'd7, 32'h0, 32'h8000_0000, 32'h0, 32'h0,
			32'h3F3F_3FFF));                                  // zero sum: fallback
		send_vertex(mk(16'd8, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF,
			32'hBF80_0000, 32'h0102_0304));                   // sum overflows: fallback
		send_vertex(mk(16'd9, 32'h0000_0001, 32'h0000_0003, 32'h007F_FFFF,
			32'hFF80_0000, 32'h0506_0708));                   // subnormals divided
		send_vertex(mk(16'd10, 32'h7F7F_FFFF, 32'h0000_0001, 32'h3F80_0000,
			32'h0, 32'h3F00_3E00));                           // nothing to repair, weights pass through
		send_vertex(mk(16'd11, 32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000,
			32'h3F80_0000, 32'h00FF_0000));                   // bone 255 cleared
		send_vertex(mk(16'd12, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF,
			32'h7F7F_FFFF, 32'h0102_0304));                   // no repair, sum not used
		send_vertex(mk(16'd13, 32'h3DCC_CCCD, 32'h3E4C_CCCD, 32'h3E99_999A,
			32'hC000_0000, 32'h3F3E_3D3C));                   // rounding in the divide
		for (int i = 0; i < 8; i++) send_vertex(rand_vertex());

		// random phases over several register settings, extremes included
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(REG_BONE_COUNT, 16'(bc_set[ph]));
			write_reg(REG_VERTEX_COUNT, vc_set[ph]);
			quiet = (ph == 3);
			if (ph == 1) long_hold = 1'b1;   // receiver holds while we keep sending
			for (int i = 0; i < 120; i++) send_vertex(rand_vertex());
			phases_run++;
		end
		vtx_in.valid = 1'b0;

		while (sb.expected_q.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
		$display("checked %0d result beats over %0d register settings", sb.beats_checked,
			phases_run + 1);
		$display("%0d rejected, %0d repaired, %0d fell back to bone 0", sb.n_rejected,
			sb.n_repaired, sb.n_fallback);
		if (sb.errors == 0 && sb.expected_q.size() == 0) begin
			$display("tb_skin_weight_sanitize_pack: done, clean");
		end else begin
			$display("tb_skin_weight_sanitize_pack: done, errors");
		end
		$finish;
	end

endmodule

/* filelist.f */
design/swsp_pkg.sv
design/swsp_in_if.sv
design/swsp_out_if.sv
design/swsp_sanitize.sv
design/swsp_sum.sv
design/swsp_div.sv
design/swsp_pack.sv
design/skin_weight_sanitize_pack.sv
test/tb_skin_weight_sanitize_pack.sv
